@@ src/rcfd_pkg.sv @@
// Package for the RC frame to PWM duty decoder.
// Holds the frame constants, configuration register codes and shared types.
// No dependencies.
`default_nettype none

package rcfd_pkg;

  localparam int unsigned FrameBytes = 32;
  localparam logic [7:0]  Hdr0       = 8'h20;
  localparam logic [7:0]  Hdr1       = 8'h40;
  localparam logic [5:0]  MotorLoPos = 6'd4;
  localparam logic [5:0]  ServoLoPos = 6'd8;
  localparam logic [16:0] InLow      = 17'd1000;

  // Pipeline depth of the mapping path, output register included.
  localparam int unsigned NumStages  = 5;

  // floor(2^36 / 125), used to divide by 125 through a multiplication.
  localparam logic [29:0] Recip125   = 30'd549755813;

  typedef enum logic [1:0] {
    CfgMotorLo = 2'd0,
    CfgMotorHi = 2'd1,
    CfgServoLo = 2'd2,
    CfgServoHi = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] chan;
    logic [15:0] lo;
    logic [15:0] hi;
  } chan_req_t;

endpackage

`default_nettype wire

@@ src/rcfd_map.sv @@
// Linear channel to duty mapping datapath, five register stages deep.
// Depends on rcfd_pkg; stage loads are driven by the pipeline control in the top level.
`default_nettype none

module rcfd_map (
  input  wire logic                            clk_i,
  input  wire logic [rcfd_pkg::NumStages-1:0]  en_i,
  input  wire rcfd_pkg::chan_req_t             req_i,
  output logic [15:0]                          duty_o
);
  import rcfd_pkg::*;

  logic [16:0] diff, span;
  logic [15:0] dmag, smag;
  logic        dneg, sneg;

  logic [15:0] dmag_q, smag_q, lo1_q;
  logic        dneg_q, sneg_q;

  logic [31:0] prod_q;
  logic        neg2_q;
  logic [15:0] lo2_q;

  logic [28:0] y;
  logic [58:0] est_full;
  logic [22:0] q3_q;
  logic [28:0] y3_q;
  logic        neg3_q;
  logic [15:0] lo3_q;

  logic [29:0] qx125, rem;
  logic [22:0] q4_d, q4_q;
  logic        neg4_q;
  logic [15:0] lo4_q;

  logic [24:0] sq, sum;
  logic [15:0] duty_d, duty_q;

  // Stage 1: magnitudes and signs of the offset and the span.
  always_comb begin
    diff = {1'b0, req_i.chan} - InLow;
    span = {1'b0, req_i.hi} - {1'b0, req_i.lo};
    dneg = diff[16];
    sneg = span[16];
    dmag = dneg ? 16'(-diff) : diff[15:0];
    smag = sneg ? 16'(-span) : span[15:0];
  end

  // Stage 3: quotient estimate of floor(y / 125), low by at most one.
  assign y        = prod_q[31:3];
  assign est_full = 59'(y) * 59'(Recip125);

  // Stage 4: correction of the estimate.
  always_comb begin
    qx125 = {q3_q, 7'b0} - {6'b0, q3_q, 1'b0} - {7'b0, q3_q};
    rem   = {1'b0, y3_q} - qx125;
    q4_d  = (rem >= 30'd125) ? q3_q + 23'd1 : q3_q;
  end

  // Stage 5: signed offset added to the low duty, then saturated.
  always_comb begin
    sq  = neg4_q ? 25'(-{2'b0, q4_q}) : {2'b0, q4_q};
    sum = {9'b0, lo4_q} + sq;
    if (sum[24]) begin
      duty_d = 16'd0;
    end else if (sum[23:16] != 8'd0) begin
      duty_d = 16'hFFFF;
    end else begin
      duty_d = sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dmag_q <= dmag;
      smag_q <= smag;
      dneg_q <= dneg;
      sneg_q <= sneg;
      lo1_q  <= req_i.lo;
    end
    if (en_i[1]) begin
      prod_q <= dmag_q * smag_q;
      neg2_q <= dneg_q ^ sneg_q;
      lo2_q  <= lo1_q;
    end
    if (en_i[2]) begin
      q3_q   <= est_full[58:36];
      y3_q   <= y;
      neg3_q <= neg2_q;
      lo3_q  <= lo2_q;
    end
    if (en_i[3]) begin
      q4_q   <= q4_d;
      neg4_q <= neg3_q;
      lo4_q  <= lo3_q;
    end
    if (en_i[4]) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

`default_nettype wire

@@ src/rc_frame_to_pwm_duty_core.sv @@
// Top level of the RC frame decoder: header search, frame byte counting, channel capture,
// configuration registers and pipeline control. Depends on rcfd_pkg and rcfd_map.
// Takes one byte per cycle unless stalled; a frame's result passes the mapping stages.
// The mapping pipeline holds up to five frame results while the output is stalled;
// the byte input stalls only when all five stages are occupied.
// Reset clears the frame state and loads the range registers with their default values.
`default_nettype none

module rc_frame_to_pwm_duty_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] motor_duty, [31:16] servo_duty
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import rcfd_pkg::*;

  logic [15:0] motor_lo_q, motor_hi_q, servo_lo_q, servo_hi_q;

  logic [5:0]  byte_count_q, byte_count_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  latch_q, latch_d;
  logic [15:0] motor_raw_q, motor_raw_d;
  logic [15:0] servo_raw_q, servo_raw_d;

  logic in_acc, frame_end;
  logic [NumStages-1:0] valid_q, valid_d, stage_rdy;
  chan_req_t motor_req, servo_req;
  logic [15:0] motor_duty, servo_duty;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    byte_count_d = byte_count_q;
    held_d       = held_q;
    latch_d      = latch_q;
    motor_raw_d  = motor_raw_q;
    servo_raw_d  = servo_raw_q;
    frame_end    = 1'b0;
    if (byte_count_q == 6'd0) begin
      held_d       = s_axis_tdata;
      byte_count_d = 6'd1;
    end else if (byte_count_q == 6'd1) begin
      if (held_q == Hdr0 && s_axis_tdata == Hdr1) begin
        byte_count_d = 6'd2;
      end else begin
        held_d = s_axis_tdata;
      end
    end else begin
      if (byte_count_q == MotorLoPos || byte_count_q == ServoLoPos) begin
        latch_d = s_axis_tdata;
      end else if (byte_count_q == MotorLoPos + 6'd1) begin
        motor_raw_d = {s_axis_tdata, latch_q};
      end else if (byte_count_q == ServoLoPos + 6'd1) begin
        servo_raw_d = {s_axis_tdata, latch_q};
      end
      if ({1'b0, byte_count_q} + 7'd1 >= 7'(FrameBytes)) begin
        frame_end    = 1'b1;
        byte_count_d = 6'd0;
      end else begin
        byte_count_d = byte_count_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= 6'd0;
      held_q       <= 8'd0;
      latch_q      <= 8'd0;
      motor_raw_q  <= 16'd0;
      servo_raw_q  <= 16'd0;
    end else if (in_acc) begin
      byte_count_q <= byte_count_d;
      held_q       <= held_d;
      latch_q      <= latch_d;
      motor_raw_q  <= motor_raw_d;
      servo_raw_q  <= servo_raw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_lo_q <= 16'h0000;
      motor_hi_q <= 16'hFFFF;
      servo_lo_q <= 16'hFFFF;
      servo_hi_q <= 16'h0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMotorLo: motor_lo_q <= cfg_data_i;
        CfgMotorHi: motor_hi_q <= cfg_data_i;
        CfgServoLo: servo_lo_q <= cfg_data_i;
        CfgServoHi: servo_hi_q <= cfg_data_i;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on in the same cycle.
  always_comb begin
    stage_rdy[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
    valid_d[0] = stage_rdy[0] ? (in_acc && frame_end) : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = stage_rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign motor_req = '{chan: motor_raw_d, lo: motor_lo_q, hi: motor_hi_q};
  assign servo_req = '{chan: servo_raw_d, lo: servo_lo_q, hi: servo_hi_q};

  rcfd_map u_motor_map (
    .clk_i  (clk_i),
    .en_i   (stage_rdy),
    .req_i  (motor_req),
    .duty_o (motor_duty)
  );

  rcfd_map u_servo_map (
    .clk_i  (clk_i),
    .en_i   (stage_rdy),
    .req_i  (servo_req),
    .duty_o (servo_duty)
  );

  assign s_axis_tready = stage_rdy[0];
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = {servo_duty, motor_duty};

  a_count_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(byte_count_q) < 7'(FrameBytes))
    else $error("byte count beyond frame length");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled with a free pipeline stage");

  a_result_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_rdy[0] && !(in_acc && frame_end)) |=> !valid_q[0])
    else $error("mapping request without a completed frame");

  a_header_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && byte_count_q == 6'd1) |=> (byte_count_q == 6'd1 || byte_count_q == 6'd2))
    else $error("header search left in an unexpected way");

endmodule

`default_nettype wire
